### sv/srlm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlm_pkg
// Shared constants, register codes and controller/datapath command types for
// the stereo RMS level meter.
// ----------------------------------------------------------------------------
package srlm_pkg;

    localparam int MAX_FRAMES_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int LEVEL_W    = 16;
    localparam int SCALED_W   = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SCALED_W-1:0]   ONE_Q16    = 17'h10000;
    localparam logic [2*LEVEL_W-1:0]  ROUND_HALF = 32'd32768;

    localparam logic [LEVEL_W-1:0] DECAY_RESET      = 16'd60948;
    localparam logic [LEVEL_W-1:0] FULL_SCALE_RESET = 16'd11141;

    localparam logic [CFG_IDX_W-1:0] REG_DECAY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd1;

    typedef struct packed {
        logic acc_en;
        logic div_load;
        logic div_step;
        logic sqrt_load;
        logic sqrt_step;
        logic mix_mul;
        logic mix_add;
        logic scale_load;
        logic scale_step;
        logic out_load;
    } srlm_cmd_t;

    typedef struct packed {
        logic out_busy;
    } srlm_stat_t;

endpackage
`default_nettype wire

### sv/srlm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlm_in_if
// Frame channel: one stereo sample pair and the end-of-buffer mark.
// ----------------------------------------------------------------------------
interface srlm_in_if
    import srlm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          last_frame;

    modport source (
        output valid,
        output left_sample,
        output right_sample,
        output last_frame,
        input  ready
    );

    modport sink (
        input  valid,
        input  left_sample,
        input  right_sample,
        input  last_frame,
        output ready
    );

endinterface
`default_nettype wire

### sv/srlm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlm_out_if
// Result channel: buffer RMS, smoothed level and scaled level.
// ----------------------------------------------------------------------------
interface srlm_out_if
    import srlm_pkg::*;
();

    logic                valid;
    logic                ready;
    logic [LEVEL_W-1:0]  buffer_rms;
    logic [LEVEL_W-1:0]  smoothed_level;
    logic [SCALED_W-1:0] scaled_level;

    modport source (
        output valid,
        output buffer_rms,
        output smoothed_level,
        output scaled_level,
        input  ready
    );

    modport sink (
        input  valid,
        input  buffer_rms,
        input  smoothed_level,
        input  scaled_level,
        output ready
    );

endinterface
`default_nettype wire

### sv/srlm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlm_ctrl
// Sequencer: accepts frames, then steps the divider, the square root, the
// smoothing multiply and the scaling divider, and hands off the result.
// ----------------------------------------------------------------------------
module srlm_ctrl
    import srlm_pkg::*;
#(
    parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    output logic       in_ready,
    input  srlm_stat_t stat,
    output srlm_cmd_t  cmd
);

    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W  = 2 * SAMPLE_BITS - 1 + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [3:0] S_ACC   = 4'd0;
    localparam logic [3:0] S_DLOAD = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_SLOAD = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_AVG   = 4'd6;
    localparam logic [3:0] S_CLOAD = 4'd7;
    localparam logic [3:0] S_SCALE = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_ACC:
            begin
                in_ready   = 1'b1;
                cmd.acc_en = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = S_DLOAD;
                end
            end
            S_DLOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = STEP_W'(SUM_W - 1);
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_SLOAD;
                end
            end
            S_SLOAD:
            begin
                cmd.sqrt_load = 1'b1;
                step_next     = STEP_W'(SAMPLE_BITS - 1);
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mix_mul = 1'b1;
                state_next  = S_AVG;
            end
            S_AVG:
            begin
                cmd.mix_add = 1'b1;
                state_next  = S_CLOAD;
            end
            S_CLOAD:
            begin
                cmd.scale_load = 1'b1;
                step_next      = STEP_W'(LEVEL_W - 1);
                state_next     = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale_step = 1'b1;
                step_next      = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free or draining this cycle
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule
`default_nettype wire

### sv/srlm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlm_datapath
// Square accumulator, restoring mean divider, digit-by-digit square root,
// smoothing multiply-add, scaling divider, config and output registers.
// ----------------------------------------------------------------------------
module srlm_datapath
    import srlm_pkg::*;
#(
    parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    input  srlm_cmd_t                     cmd,
    output srlm_stat_t                    stat,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [LEVEL_W-1:0]            out_rms,
    output logic [LEVEL_W-1:0]            out_avg,
    output logic [SCALED_W-1:0]           out_scaled
);

    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W  = SQ_W + CNT_W;
    localparam int DVS_W  = CNT_W + 1;
    localparam int RAD_W  = 2 * SAMPLE_BITS;
    localparam int SREM_W = SAMPLE_BITS + 1;

    // configuration
    logic [LEVEL_W-1:0] decay_reg, decay_next;
    logic [LEVEL_W-1:0] full_scale_reg, full_scale_next;

    // accumulator
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // mean divider
    logic [SUM_W-1:0] dq_reg, dq_next;
    logic [DVS_W-1:0] drem_reg, drem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    // square root
    logic [RAD_W-1:0]       srad_reg, srad_next;
    logic [SREM_W-1:0]      srem_reg, srem_next;
    logic [SAMPLE_BITS-1:0] sroot_reg, sroot_next;

    // smoothing
    logic [2*LEVEL_W-1:0] prod_a_reg, prod_a_next;
    logic [2*LEVEL_W:0]   prod_b_reg, prod_b_next;
    logic [LEVEL_W-1:0]   avg_reg, avg_next;

    // scaling divider
    logic [LEVEL_W-1:0] crem_reg, crem_next;
    logic [LEVEL_W-1:0] cquo_reg, cquo_next;
    logic               clamp_reg, clamp_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]  out_rms_reg, out_rms_next;
    logic [LEVEL_W-1:0]  out_avg_reg, out_avg_next;
    logic [SCALED_W-1:0] out_scaled_reg, out_scaled_next;

    logic signed [2*SAMPLE_BITS-1:0] sq_l_full, sq_r_full;
    logic [SUM_W-1:0]                frame_sq;
    logic [DVS_W:0]                  div_trial, div_diff;
    logic                            div_ge;
    logic [SREM_W+1:0]               rt_trial, rt_test, rt_diff;
    logic                            rt_ge;
    logic [SAMPLE_BITS+LEVEL_W-1:0]  rms_wide;
    logic [LEVEL_W-1:0]              rms_q16;
    logic [LEVEL_W:0]                weight_new;
    logic [2*LEVEL_W+1:0]            mix_sum;
    logic [LEVEL_W:0]                sc_trial, sc_diff;
    logic                            sc_ge;
    logic [SCALED_W-1:0]             scaled_value;

    assign sq_l_full = left_sample * left_sample;
    assign sq_r_full = right_sample * right_sample;
    assign frame_sq  = SUM_W'(sq_l_full[SQ_W-1:0]) + SUM_W'(sq_r_full[SQ_W-1:0]);

    assign div_trial = {drem_reg, dq_reg[SUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, dvs_reg};
    assign div_diff  = div_trial - {1'b0, dvs_reg};

    assign rt_trial = {srem_reg, srad_reg[RAD_W-1 -: 2]};
    assign rt_test  = {1'b0, sroot_reg, 2'b01};
    assign rt_ge    = rt_trial >= rt_test;
    assign rt_diff  = rt_trial - rt_test;

    // root is in units of 2^-SAMPLE_BITS; realign to Q0.16
    assign rms_wide = {sroot_reg, {LEVEL_W{1'b0}}};
    assign rms_q16  = rms_wide[SAMPLE_BITS +: LEVEL_W];

    assign weight_new = ONE_Q16 - {1'b0, decay_reg};
    assign mix_sum    = (2*LEVEL_W+2)'(prod_a_reg) + (2*LEVEL_W+2)'(prod_b_reg)
                      + (2*LEVEL_W+2)'(ROUND_HALF);

    assign sc_trial = {crem_reg, 1'b0};
    assign sc_ge    = sc_trial >= {1'b0, full_scale_reg};
    assign sc_diff  = sc_trial - {1'b0, full_scale_reg};

    always_comb
    begin
        if (clamp_reg)
        begin
            scaled_value = (avg_reg != '0) ? ONE_Q16 : '0;
        end
        else
        begin
            scaled_value = {1'b0, cquo_reg};
        end
    end

    always_comb
    begin
        decay_next      = decay_reg;
        full_scale_next = full_scale_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        dq_next         = dq_reg;
        drem_next       = drem_reg;
        dvs_next        = dvs_reg;
        srad_next       = srad_reg;
        srem_next       = srem_reg;
        sroot_next      = sroot_reg;
        prod_a_next     = prod_a_reg;
        prod_b_next     = prod_b_reg;
        avg_next        = avg_reg;
        crem_next       = crem_reg;
        cquo_next       = cquo_reg;
        clamp_next      = clamp_reg;
        out_valid_next  = out_valid_reg;
        out_rms_next    = out_rms_reg;
        out_avg_next    = out_avg_reg;
        out_scaled_next = out_scaled_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_DECAY:      decay_next      = cfg_wdata;
                REG_FULL_SCALE: full_scale_next = cfg_wdata;
                default:        ;
            endcase
        end

        // drop frames once the count is saturated
        if (cmd.acc_en && (count_reg < CNT_W'(MAX_FRAMES)))
        begin
            sum_next   = sum_reg + frame_sq;
            count_next = count_reg + 1'b1;
        end

        if (cmd.div_load)
        begin
            dq_next    = sum_reg;
            drem_next  = '0;
            dvs_next   = {count_reg, 1'b0};
            sum_next   = '0;
            count_next = '0;
        end

        if (cmd.div_step)
        begin
            dq_next   = {dq_reg[SUM_W-2:0], div_ge};
            drem_next = div_ge ? div_diff[DVS_W-1:0] : div_trial[DVS_W-1:0];
        end

        if (cmd.sqrt_load)
        begin
            srad_next  = dq_reg[RAD_W-1:0];
            srem_next  = '0;
            sroot_next = '0;
        end

        if (cmd.sqrt_step)
        begin
            srad_next  = {srad_reg[RAD_W-3:0], 2'b00};
            srem_next  = rt_ge ? rt_diff[SREM_W-1:0] : rt_trial[SREM_W-1:0];
            sroot_next = {sroot_reg[SAMPLE_BITS-2:0], rt_ge};
        end

        if (cmd.mix_mul)
        begin
            prod_a_next = avg_reg * decay_reg;
            prod_b_next = rms_q16 * weight_new;
        end

        if (cmd.mix_add)
        begin
            avg_next = mix_sum[2*LEVEL_W-1:LEVEL_W];
        end

        if (cmd.scale_load)
        begin
            clamp_next = avg_reg >= full_scale_reg;
            crem_next  = avg_reg;
            cquo_next  = '0;
        end

        if (cmd.scale_step)
        begin
            crem_next = sc_ge ? sc_diff[LEVEL_W-1:0] : sc_trial[LEVEL_W-1:0];
            cquo_next = {cquo_reg[LEVEL_W-2:0], sc_ge};
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_rms_next    = rms_q16;
            out_avg_next    = avg_reg;
            out_scaled_next = scaled_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg      <= DECAY_RESET;
            full_scale_reg <= FULL_SCALE_RESET;
            sum_reg        <= '0;
            count_reg      <= '0;
            avg_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            decay_reg      <= decay_next;
            full_scale_reg <= full_scale_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            avg_reg        <= avg_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg         <= dq_next;
        drem_reg       <= drem_next;
        dvs_reg        <= dvs_next;
        srad_reg       <= srad_next;
        srem_reg       <= srem_next;
        sroot_reg      <= sroot_next;
        prod_a_reg     <= prod_a_next;
        prod_b_reg     <= prod_b_next;
        crem_reg       <= crem_next;
        cquo_reg       <= cquo_next;
        clamp_reg      <= clamp_next;
        out_rms_reg    <= out_rms_next;
        out_avg_reg    <= out_avg_next;
        out_scaled_reg <= out_scaled_next;
    end

    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_rms       = out_rms_reg;
    assign out_avg       = out_avg_reg;
    assign out_scaled    = out_scaled_reg;

endmodule
`default_nettype wire

### sv/stereo_rms_level_meter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_rms_level_meter_core
// Stereo RMS meter with exponential smoothing and full-scale mapping.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one stereo frame per transfer; last_frame closes a buffer.
//   Within a buffer a frame is taken every cycle. After the closing frame the
//   block holds in_ch.ready low while it computes, then presents one result
//   on out_ch (buffer_rms, smoothed_level, scaled_level).
//   After the closing transfer the data passes the bit-serial mean divider
//   (SUM_W steps, SUM_W = 2*SAMPLE_BITS - 1 + clog2(MAX_FRAMES+1)), the
//   square root (SAMPLE_BITS steps), the smoothing multiply-add and the
//   scaling divider (16 steps) before the result reaches out_ch.
//   Frames beyond MAX_FRAMES in one buffer are taken but not counted.
//   cfg_we writes decay_factor (index 0) or full_scale_level (index 1).
//   Reset clears the sum, the count and the smoothed level and restores the
//   register defaults. A stalled result stays in the output register while
//   the next buffer accumulates; a new result waits until it is taken.
// ----------------------------------------------------------------------------
module stereo_rms_level_meter_core
    import srlm_pkg::*;
#(
    parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    srlm_in_if.sink               in_ch,
    srlm_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    srlm_cmd_t  cmd;
    srlm_stat_t stat;

    srlm_ctrl #(
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_last  (in_ch.last_frame),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srlm_datapath #(
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .left_sample  (in_ch.left_sample),
        .right_sample (in_ch.right_sample),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .out_rms      (out_ch.buffer_rms),
        .out_avg      (out_ch.smoothed_level),
        .out_scaled   (out_ch.scaled_level)
    );

    // one controller command at a time
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command active");

    // a closing frame transfer stops frame intake
    a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.last_frame) |=> !in_ch.ready)
        else $error("frame intake continued after buffer close");

    // never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_ch.valid && !out_ch.ready))
        else $error("pending result overwritten");

    a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.scaled_level <= ONE_Q16))
        else $error("scaled level above one");

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo RMS level meter. Frames go in on the
// frame channel with random gaps, results are taken with random stalls, and
// every result is compared with a level tracker that follows the square sum,
// the frame count and the smoothed level at the block's own widths.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [15:0] buffer_rms;
    logic [15:0] smoothed_level;
    logic [16:0] scaled_level;
} level_result_t;

class meter_scoreboard;

    level_result_t expected_levels[$];
    logic [63:0]   square_sum;
    int unsigned   frame_count;
    logic [15:0]   level_average;
    logic [15:0]   decay_factor;
    logic [15:0]   full_scale_level;
    int            errors;

    function new();
        square_sum       = '0;
        frame_count      = 0;
        level_average    = '0;
        decay_factor     = srlm_pkg::DECAY_RESET;
        full_scale_level = srlm_pkg::FULL_SCALE_RESET;
        errors           = 0;
    endfunction

    function int pending();
        return expected_levels.size();
    endfunction

    function void write_reg(input logic [1:0] index, input logic [15:0] data);
        if (index == srlm_pkg::REG_DECAY)
            decay_factor = data;
        else if (index == srlm_pkg::REG_FULL_SCALE)
            full_scale_level = data;
    endfunction

    // bitwise floor square root, one result bit per pass
    function logic [31:0] floor_root(input logic [63:0] x);
        logic [31:0] root;
        logic [31:0] trial;
        int          b;
        root = '0;
        for (b = 31; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= x)
                root = trial;
        end
        return root;
    endfunction

    function void note_frame(input logic signed [15:0] left, input logic signed [15:0] right,
                             input logic last);
        longint        l_wide;
        longint        r_wide;
        logic [63:0]   mean_sq;
        logic [31:0]   root;
        logic [63:0]   mix;
        logic [63:0]   quotient;
        level_result_t lvl;
        // saturated count: drop the frame from the sum
        if (frame_count < srlm_pkg::MAX_FRAMES_DEF)
        begin
            l_wide = left;
            r_wide = right;
            square_sum += 64'(l_wide * l_wide) + 64'(r_wide * r_wide);
            frame_count++;
        end
        if (!last)
            return;
        lvl.buffer_rms = '0;
        if (frame_count != 0)
        begin
            mean_sq = square_sum / (64'(frame_count) * 64'd2);
            root = floor_root(mean_sq);
            lvl.buffer_rms = (root > 32'd65535) ? 16'hFFFF : root[15:0];
        end
        mix = 64'(level_average) * 64'(decay_factor)
            + 64'(lvl.buffer_rms) * (64'd65536 - 64'(decay_factor)) + 64'd32768;
        level_average = mix[31:16];
        lvl.smoothed_level = level_average;
        if (full_scale_level == 16'd0)
            lvl.scaled_level = (level_average != 16'd0) ? srlm_pkg::ONE_Q16 : '0;
        else
        begin
            quotient = {32'b0, level_average, 16'b0} / 64'(full_scale_level);
            lvl.scaled_level = (quotient > 64'd65536) ? srlm_pkg::ONE_Q16 : quotient[16:0];
        end
        expected_levels.push_back(lvl);
        square_sum  = '0;
        frame_count = 0;
    endfunction

    function void check_result(input logic [15:0] rms, input logic [15:0] smooth,
                               input logic [16:0] scaled);
        level_result_t want;
        if (expected_levels.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR: result with no closed buffer: rms %0d smooth %0d scaled %0d",
                         rms, smooth, scaled);
            return;
        end
        want = expected_levels.pop_front();
        if (want.buffer_rms !== rms || want.smoothed_level !== smooth
            || want.scaled_level !== scaled)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR: rms %0d/%0d smooth %0d/%0d scaled %0d/%0d (expected/actual)",
                         want.buffer_rms, rms, want.smoothed_level, smooth,
                         want.scaled_level, scaled);
        end
    endfunction

endclass

module tb;

    import srlm_pkg::*;

    localparam int SB             = SAMPLE_BITS_DEF;
    localparam int SETTLE_CYCLES  = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam int IDLE_LIMIT     = 4000;
    localparam int RANDOM_FRAMES  = 2000;
    localparam int PHASE_FRAMES   = 200;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int STYLE_FULL     = 0;
    localparam int STYLE_QUIET    = 1;
    localparam int STYLE_MODERATE = 2;
    localparam int STYLE_EDGE     = 3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    srlm_in_if #(.SAMPLE_BITS(SB)) in_ch ();
    srlm_out_if                    out_ch ();

    meter_scoreboard sb = new();

    int sender_calm   = 0;
    int receiver_calm = 0;
    bit hold_output   = 1'b0;
    int idle_cycles   = 0;

    stereo_rms_level_meter_core #(
        .MAX_FRAMES  (MAX_FRAMES_DEF),
        .SAMPLE_BITS (SB)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // random gap from 0 to 10, with stretches of back-to-back transfers
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic logic signed [SB-1:0] draw_sample(input int style);
        case (style)
            STYLE_QUIET:    return SB'($urandom_range(0, 512) - 256);
            STYLE_MODERATE: return SB'($urandom_range(0, 8192) - 4096);
            STYLE_EDGE:
            begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    3:       return 16'shFFFF;
                    default: return 16'sh0001;
                endcase
            end
            default:        return SB'($urandom);
        endcase
    endfunction

    task automatic send_frame(input logic signed [SB-1:0] left,
                              input logic signed [SB-1:0] right, input logic last);
        int gap;
        gap = draw_gap(sender_calm);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.left_sample  <= left;
        in_ch.right_sample <= right;
        in_ch.last_frame   <= last;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_frame(left, right, last);
    endtask

    // drop valid and wait until every pending result is out, then let the
    // block finish any work still in flight
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_meter(input logic [15:0] decay, input logic [15:0] full_scale,
                                 input logic [CFG_IDX_W-1:0] spare_index);
        logic [15:0] junk;
        junk = 16'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DECAY;
        cfg_wdata <= decay;
        @(posedge clk);
        sb.write_reg(REG_DECAY, decay);
        cfg_index <= REG_FULL_SCALE;
        cfg_wdata <= full_scale;
        @(posedge clk);
        sb.write_reg(REG_FULL_SCALE, full_scale);
        // index beyond the register list: must be ignored
        cfg_index <= spare_index;
        cfg_wdata <= junk;
        @(posedge clk);
        sb.write_reg(spare_index, junk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
            $display("tb: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : result_sink
        int gap;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_output)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            gap = draw_gap(receiver_calm);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            sb.check_result(out_ch.buffer_rms, out_ch.smoothed_level, out_ch.scaled_level);
        end
    end

    initial
    begin : frame_source
        int          phase;
        int          frames_done;
        int          budget;
        int          len;
        int          style;
        int          i;
        logic [15:0] decay;
        logic [15:0] full_scale;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_DECAY;
        cfg_wdata          <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.left_sample  <= '0;
        in_ch.right_sample <= '0;
        in_ch.last_frame   <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: single-frame buffers at the sample extremes, then one four-frame buffer
        send_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_frame(16'sh8000, 16'sh8000, 1'b1);
        send_frame(16'sh0000, 16'sh0000, 1'b1);
        send_frame(16'sh7FFF, 16'sh8000, 1'b1);
        send_frame(16'sh5555, 16'shAAAA, 1'b0);
        send_frame(16'shAAAA, 16'sh5555, 1'b0);
        send_frame(16'sh0001, 16'shFFFF, 1'b0);
        send_frame(16'sh0100, 16'sh0200, 1'b1);
        settle();

        // no smoothing, widest full scale
        program_meter(16'd0, 16'hFFFF, REG_SPARE_A);
        send_frame(16'sh4000, 16'shC000, 1'b1);
        send_frame(16'sh1234, 16'shEDCB, 1'b1);
        send_frame(16'sh0000, 16'sh0000, 1'b1);
        settle();

        // heaviest smoothing, smallest nonzero full scale
        program_meter(16'hFFFF, 16'd1, REG_SPARE_B);
        send_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_frame(16'sh8000, 16'sh0000, 1'b1);
        settle();

        // zero full scale: zero level, then nonzero level
        program_meter(16'd0, 16'd0, REG_SPARE_A);
        send_frame(16'sh0000, 16'sh0000, 1'b1);
        send_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
        settle();

        phase = 0;
        frames_done = 0;
        while (frames_done < RANDOM_FRAMES)
        begin
            case ($urandom_range(0, 4))
                0:       decay = 16'd0;
                1:       decay = 16'hFFFF;
                2:       decay = DECAY_RESET;
                default: decay = 16'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0:       full_scale = 16'd0;
                1:       full_scale = 16'd1;
                2:       full_scale = 16'hFFFF;
                3:       full_scale = FULL_SCALE_RESET;
                4:       full_scale = 16'($urandom_range(1, 4096));
                default: full_scale = 16'($urandom);
            endcase
            program_meter(decay, full_scale, $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B);
            // stall the result side while frames keep coming
            if (phase == 1)
                hold_output = 1'b1;
            budget = 0;
            while (budget < PHASE_FRAMES)
            begin
                if (phase == 0 && budget == 0)
                    len = 300;
                else if ($urandom_range(0, 99) < 70)
                    len = $urandom_range(1, 16);
                else if ($urandom_range(0, 24) != 0)
                    len = $urandom_range(17, 64);
                else
                    len = $urandom_range(250, 300);
                style = $urandom_range(STYLE_FULL, STYLE_EDGE);
                for (i = 0; i < len; i++)
                    send_frame(draw_sample(style), draw_sample(style), i == len - 1);
                budget += (len > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : len;
            end
            settle();
            frames_done += budget;
            phase++;
        end

        if (sb.pending() != 0)
        begin
            sb.errors++;
            $display("ERROR: %0d results never arrived", sb.pending());
        end
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

### stereo_rms_level_meter_core.f
sv/srlm_pkg.sv
sv/srlm_in_if.sv
sv/srlm_out_if.sv
sv/srlm_ctrl.sv
sv/srlm_datapath.sv
sv/stereo_rms_level_meter_core.sv
tb/tb.sv
